### hdl/utf8_line_splitting_decoder_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 line splitting decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_LINE_SPLITTING_DECODER_DEFINES_SVH
`define UTF8_LINE_SPLITTING_DECODER_DEFINES_SVH

`define ULSD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define ULSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ULSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ulsd_pkg.sv
// ----------------------------------------------------------------------------
// ulsd_pkg
// Types and constants shared by the UTF-8 line splitting decoder.
// ----------------------------------------------------------------------------
package ulsd_pkg;

    localparam int MAX_LINES   = 1024;
    localparam int MAX_COLUMNS = 256;

    localparam int ROW_W = 10;
    localparam int COL_W = 8;
    localparam int CP_W  = 21;
    localparam int CNT_W = 11;

    localparam logic [CNT_W-1:0] LINES_MAX = CNT_W'(MAX_LINES);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(MAX_COLUMNS - 1);

    localparam logic [CP_W-1:0] CP_LF          = CP_W'(32'h0A);
    localparam logic [CP_W-1:0] CP_CR          = CP_W'(32'h0D);
    localparam logic [CP_W-1:0] CP_REPLACEMENT = CP_W'(32'hFFFD);

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_LINE    = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        t_kind             kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CP_W-1:0]   codepoint;
        logic [CNT_W-1:0]  line_count;
        logic              final_res;
    } t_out;

    typedef struct packed {
        logic [2:0][CP_W-1:0] cps;
        logic [1:0]           cnt;
        logic                 eof;
    } t_job;

endpackage

### hdl/ulsd_decode.sv
// ----------------------------------------------------------------------------
// ulsd_decode
// Collects the bytes of a UTF-8 sequence and registers the decoded
// codepoints of each completed sequence, or of an end-of-file flush, as a job.
// ----------------------------------------------------------------------------
`include "utf8_line_splitting_decoder_defines.svh"

module ulsd_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ulsd_pkg::t_in  i_in_data,
    output logic           o_job_valid,
    output ulsd_pkg::t_job o_job,
    input  logic           i_job_done
);
    import ulsd_pkg::*;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] len;
        if (c[7] == 1'b0) begin
            len = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (c[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic logic [CP_W-1:0] decode_single(input logic [7:0] c);
        logic [CP_W-1:0] cp;
        cp = c[7] ? CP_REPLACEMENT : CP_W'(c);
        return cp;
    endfunction

    function automatic logic [CP_W-1:0] decode_full(input logic [3:0][7:0] b,
                                                    input logic [2:0] len);
        logic [CP_W-1:0] cp;
        case (len)
            3'd2:    cp = CP_W'({b[0][4:0], b[1][5:0]});
            3'd3:    cp = CP_W'({b[0][3:0], b[1][5:0], b[2][5:0]});
            3'd4:    cp = CP_W'({b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]});
            default: cp = decode_single(b[0]);
        endcase
        return cp;
    endfunction

    logic [7:0]      r_pend [3];
    logic [1:0]      r_pcnt;
    logic            r_job_v;
    t_job            r_job;

    logic [3:0][7:0] seq;
    logic [2:0]      seq_n;
    logic [2:0]      lead0;
    logic            hold;
    logic            accept;
    t_job            n_job;

    always_comb begin
        seq = '0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < r_pcnt) begin
                seq[i] = r_pend[i];
            end
        end
        seq[r_pcnt] = i_in_data.data_byte;
        seq_n = {1'b0, r_pcnt} + 3'd1;
        lead0 = lead_len(seq[0]);
        hold  = !i_in_data.end_of_file && (lead0 > seq_n);
    end

    always_comb begin
        n_job     = '0;
        n_job.eof = i_in_data.end_of_file;
        if (lead0 <= seq_n) begin
            n_job.cps[0] = decode_full(seq, lead0);
            n_job.cnt    = 2'd1;
        end else begin
            n_job.cps[0] = CP_REPLACEMENT;
            case (r_pcnt)
                2'd1: begin
                    n_job.cps[1] = decode_single(seq[1]);
                    n_job.cnt    = 2'd2;
                end
                2'd2: begin
                    if (lead_len(seq[1]) == 3'd2) begin
                        n_job.cps[1] = CP_W'({seq[1][4:0], seq[2][5:0]});
                        n_job.cnt    = 2'd2;
                    end else begin
                        n_job.cps[1] = decode_single(seq[1]);
                        n_job.cps[2] = decode_single(seq[2]);
                        n_job.cnt    = 2'd3;
                    end
                end
                default: begin
                    n_job.cnt = 2'd1;
                end
            endcase
        end
    end

    assign o_in_ready  = !r_job_v || i_job_done;
    assign accept      = i_in_valid && o_in_ready;
    assign o_job_valid = r_job_v;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt  <= '0;
            r_job_v <= 1'b0;
        end else begin
            if (accept) begin
                r_pcnt <= hold ? r_pcnt + 2'd1 : 2'd0;
            end
            if (accept && !hold) begin
                r_job_v <= 1'b1;
            end else if (i_job_done) begin
                r_job_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hold) begin
            r_pend[r_pcnt] <= i_in_data.data_byte;
        end
        if (accept && !hold) begin
            r_job <= n_job;
        end
    end

    `ULSD_ASSERT_IMPL(a_job_nonempty, r_job_v, r_job.cnt != 2'd0, "Job holds no codepoint.")
    `ULSD_ASSERT_NEXT(a_eof_flush, accept && i_in_data.end_of_file, (r_pcnt == 2'd0) && r_job_v, "End of file left bytes pending.")

endmodule

### hdl/ulsd_place.sv
// ----------------------------------------------------------------------------
// ulsd_place
// Places each job's codepoints into the line grid, one step per cycle while
// the output register is free or taken, and holds each result there until taken.
// ----------------------------------------------------------------------------
`include "utf8_line_splitting_decoder_defines.svh"

module ulsd_place (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  ulsd_pkg::t_job i_job,
    output logic           o_job_done,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ulsd_pkg::t_out o_out_data
);
    import ulsd_pkg::*;

    logic [CNT_W-1:0] r_lines;
    logic [COL_W-1:0] r_len;
    logic [1:0]       r_step;
    logic             r_out_v;
    t_out             r_out;

    logic [CNT_W-1:0] n_lines;
    logic [COL_W-1:0] n_len;
    t_out             n_out;
    logic             emit;
    logic             adv;
    logic             last;
    logic             is_summary;
    logic [2:0]       total;
    logic [CP_W-1:0]  cur_cp;
    logic [ROW_W-1:0] row;

    assign adv        = i_job_valid && (!r_out_v || i_out_ready);
    assign total      = {1'b0, i_job.cnt} + {2'b00, i_job.eof};
    assign last       = ({1'b0, r_step} + 3'd1) == total;
    assign is_summary = r_step >= i_job.cnt;
    assign row        = ROW_W'(r_lines - CNT_W'(1));

    always_comb begin
        case (r_step)
            2'd0:    cur_cp = i_job.cps[0];
            2'd1:    cur_cp = i_job.cps[1];
            2'd2:    cur_cp = i_job.cps[2];
            default: cur_cp = '0;
        endcase
    end

    always_comb begin
        n_lines = r_lines;
        n_len   = r_len;
        emit    = 1'b0;
        n_out   = '0;
        n_out.row        = row;
        n_out.column     = r_len;
        n_out.line_count = r_lines;
        if (is_summary) begin
            emit            = 1'b1;
            n_out.kind      = KIND_SUMMARY;
            n_out.final_res = 1'b1;
            n_lines         = CNT_W'(1);
            n_len           = '0;
        end else if (cur_cp == CP_LF) begin
            if (r_lines < LINES_MAX) begin
                emit             = 1'b1;
                n_out.kind       = KIND_LINE;
                n_out.line_count = r_lines + CNT_W'(1);
                n_lines          = r_lines + CNT_W'(1);
                n_len            = '0;
            end
        end else if (cur_cp != CP_CR) begin
            if (r_len < COL_LAST) begin
                emit            = 1'b1;
                n_out.kind      = KIND_CHAR;
                n_out.codepoint = cur_cp;
                n_len           = r_len + COL_W'(1);
            end
        end
    end

    assign o_job_done  = adv && last;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines <= CNT_W'(1);
            r_len   <= '0;
            r_step  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (adv) begin
                r_lines <= n_lines;
                r_len   <= n_len;
                r_step  <= last ? 2'd0 : r_step + 2'd1;
                r_out_v <= emit;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= n_out;
        end
    end

    `ULSD_ASSERT_IMPL(a_final_flag, r_out_v, r_out.final_res == (r_out.kind == KIND_SUMMARY), "Final flag does not match result kind.")
    `ULSD_ASSERT_ALWAYS(a_lines_range, (r_lines != '0) && (r_lines <= LINES_MAX), "Line count out of range.")
    `ULSD_ASSERT_NEXT(a_summary_reset, adv && is_summary, (r_lines == CNT_W'(1)) && (r_len == '0), "Grid not reset after summary.")

endmodule

### hdl/utf8_line_splitting_decoder.sv
// ----------------------------------------------------------------------------
// utf8_line_splitting_decoder
// Streaming UTF-8 decoder that places codepoints into a grid of lines.
// The input channel takes one file byte per transaction, with an end-of-file
// flag on the last byte. The output channel gives one result per transaction:
// a stored character, a closed line, or the end-of-file summary.
// A byte that completes a sequence is registered as a job, whose results then
// pass through the output register; lead and continuation bytes that only
// extend a sequence give none. One byte is accepted per cycle while the job
// register is empty or its job is done, else the input waits until the
// placement stage has placed the job's codepoints and any end-of-file summary.
// Reset leaves one empty line and no pending bytes; no clearing pass is needed.
// When the receiver stalls, the output register holds its transaction and the
// stall reaches the input once the job register is also full.
// ----------------------------------------------------------------------------
module utf8_line_splitting_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ulsd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ulsd_pkg::t_out o_out_data
);
    import ulsd_pkg::*;

    logic job_valid;
    logic job_done;
    t_job job;

    ulsd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_done  (job_done)
    );

    ulsd_place u_place (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_done  (job_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### sim/ulsd_checker.sv
// ----------------------------------------------------------------------------
// ulsd_checker
// Watches both channels of the UTF-8 line splitting decoder. Every accepted
// input byte is run through a local decoder and line grid, which queues the
// grid updates the block has to give. Every accepted output transaction is
// compared field by field with the oldest queued update.
// ----------------------------------------------------------------------------
module ulsd_checker
    import ulsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] held [3];
    int         held_n;
    int         lines_used;
    int         cur_len;
    int         mismatches;
    t_out       grid_updates [$];

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        mismatches = 0;
    end

    function automatic int lead_len(logic [7:0] c);
        if (c < 8'h80) return 1;
        if ((c & 8'hE0) == 8'hC0) return 2;
        if ((c & 8'hF0) == 8'hE0) return 3;
        if ((c & 8'hF8) == 8'hF0) return 4;
        return 1;
    endfunction

    function automatic void push_update(t_kind kind, int row, int col, logic [CP_W-1:0] cp,
                                        int count, logic fin);
        t_out r;
        r.kind       = kind;
        r.row        = ROW_W'(row);
        r.column     = COL_W'(col);
        r.codepoint  = cp;
        r.line_count = CNT_W'(count);
        r.final_res  = fin;
        grid_updates.push_back(r);
    endfunction

    function automatic void place_codepoint(logic [CP_W-1:0] cp);
        int row;
        row = lines_used - 1;
        if (cp == CP_LF) begin
            if (lines_used < MAX_LINES) begin
                lines_used++;
                push_update(KIND_LINE, row, cur_len, '0, lines_used, 1'b0);
                cur_len = 0;
            end
        end else if (cp != CP_CR && cur_len < MAX_COLUMNS - 1) begin
            push_update(KIND_CHAR, row, cur_len, cp, lines_used, 1'b0);
            cur_len++;
        end
    endfunction

    function automatic void decode_byte(t_in item);
        logic [7:0]      seq [4];
        logic [CP_W-1:0] cp;
        int              n;
        int              pos;
        int              need;
        int              step;
        for (int i = 0; i < held_n; i++) seq[i] = held[i];
        seq[held_n] = item.data_byte;
        n = held_n + 1;
        if (!item.end_of_file && lead_len(seq[0]) > n) begin
            for (int i = 0; i < n; i++) held[i] = seq[i];
            held_n = n;
            return;
        end
        held_n = 0;
        pos = 0;
        while (pos < n) begin
            need = lead_len(seq[pos]);
            step = 1;
            if (seq[pos] < 8'h80) begin
                cp = CP_W'(seq[pos]);
            end else if (need > 1 && n - pos >= need) begin
                step = need;
                case (need)
                    2: cp = CP_W'({seq[pos][4:0], seq[pos+1][5:0]});
                    3: cp = CP_W'({seq[pos][3:0], seq[pos+1][5:0], seq[pos+2][5:0]});
                    default: cp = {seq[pos][2:0], seq[pos+1][5:0], seq[pos+2][5:0],
                                   seq[pos+3][5:0]};
                endcase
            end else begin
                cp = CP_REPLACEMENT;
            end
            place_codepoint(cp);
            pos += step;
        end
        if (item.end_of_file) begin
            push_update(KIND_SUMMARY, lines_used - 1, cur_len, '0, lines_used, 1'b1);
            lines_used = 1;
            cur_len    = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            held_n     = 0;
            lines_used = 1;
            cur_len    = 0;
            grid_updates.delete();
        end else begin
            if (i_in_valid && i_in_ready) decode_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (grid_updates.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = grid_updates.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_out_data.kind));
                    check_field("row", 32'(want.row), 32'(i_out_data.row));
                    check_field("column", 32'(want.column), 32'(i_out_data.column));
                    check_field("codepoint", 32'(want.codepoint), 32'(i_out_data.codepoint));
                    check_field("line_count", 32'(want.line_count),
                                32'(i_out_data.line_count));
                    check_field("final_res", 32'(want.final_res), 32'(i_out_data.final_res));
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= grid_updates.size();
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the UTF-8 line splitting decoder: directed ASCII, invalid,
// two-, three- and four-byte and cut-off sequences, a line longer than the
// column limit, a long receiver stall, then random files of mostly well-formed
// UTF-8 with noise and cut sequences. Checking is done by ulsd_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import ulsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_BYTES = 30;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    int errors;
    int pending;
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    bit hold_req   = 1'b0;
    int random_sent = 0;

    logic [8:0] directed_bytes [24] = '{
        9'h041, 9'h000, 9'h07F, 9'h0FF, 9'h080, 9'h0C3, 9'h0A9, 9'h0E2,
        9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h00D, 9'h00A,
        9'h0C0, 9'h080, 9'h0F8, 9'h0E2, 9'h182, 9'h0F0, 9'h041, 9'h10A
    };

    utf8_line_splitting_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    ulsd_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : receiver
        int n;
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= {b, eof};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic send_random_file();
        logic [7:0] fbytes [$];
        int         chars;
        int         cut;
        chars = $urandom_range(1, 16);
        repeat (chars) begin
            case ($urandom_range(0, 15))
                6:  fbytes.push_back(8'h0A);
                7:  fbytes.push_back(8'h0D);
                8, 9: begin
                    fbytes.push_back({3'b110, 5'($urandom_range(0, 31))});
                    fbytes.push_back(tail_byte());
                end
                10, 11: begin
                    fbytes.push_back({4'b1110, 4'($urandom_range(0, 15))});
                    repeat (2) fbytes.push_back(tail_byte());
                end
                12: begin
                    fbytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
                    repeat (3) fbytes.push_back(tail_byte());
                end
                13: fbytes.push_back(8'($urandom_range(0, 255)));
                14: fbytes.push_back(tail_byte());
                15: fbytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                default: fbytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            endcase
        end
        if (fbytes.size() > 1 && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, (fbytes.size() > 3) ? 3 : fbytes.size() - 1);
            repeat (cut) void'(fbytes.pop_back());
        end
        foreach (fbytes[i]) send_byte(fbytes[i], i == fbytes.size() - 1);
        random_sent += fbytes.size();
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        wait_drained();

        // One line longer than the column limit.
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int i = 0; i < 260; i++) send_byte(8'($urandom_range(8'h20, 8'h7E)), i == 259);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        wait_drained();

        // The receiver holds off while the sender keeps offering bytes.
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(8'h20, 8'h7E)), i == 39);
        wait_drained();

        while (random_sent < RANDOM_BYTES) begin
            send_random_file();
        end
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/ulsd_pkg.sv
hdl/ulsd_decode.sv
hdl/ulsd_place.sv
hdl/utf8_line_splitting_decoder.sv
sim/ulsd_checker.sv
sim/tb_top.sv
